>>> rtl/fwt_pkg.sv
// Shared types and constants of the wildcard flow table.
package fwt_pkg;

  typedef struct packed {
    logic [31:0] in_port;
    logic [15:0] eth_type;
    logic [47:0] eth_src;
    logic [47:0] eth_dst;
    logic        syn;
    logic        ack;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
  } key_t;

  typedef struct packed {
    logic        expired;
    logic        match;
    logic [31:0] hits_new;
  } eval_t;

  localparam logic       CMD_ADD    = 1'b0;
  localparam logic       CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_ADDED = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int WB_IN_PORT  = 0;
  localparam int WB_ETH_TYPE = 1;
  localparam int WB_ETH_SRC  = 2;
  localparam int WB_ETH_DST  = 3;
  localparam int WB_ACK      = 4;
  localparam int WB_IP_SRC   = 5;
  localparam int WB_IP_DST   = 6;

  localparam logic [31:0] PORT_ANY        = 32'hFFFF_FFFF;
  localparam logic [31:0] HITS_MAX        = 32'hFFFF_FFFF;
  localparam logic [31:0] ERASED_MAX      = 32'hFFFF_FFFF;
  localparam logic [15:0] SYN_LIMIT_RESET = 16'd5;
  localparam logic        REG_SYN_LIMIT   = 1'b0;

endpackage

>>> rtl/fwt_idx_ram.sv
// Single-port-write, registered-read RAM of slot indexes.
module fwt_idx_ram #(
  parameter int DEPTH = 16,
  parameter int W     = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fwt_entry_mem.sv
// Flow entry store: key, wildcards, expiry, idle timeout, port and hit count per slot.
module fwt_entry_mem #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  fwt_pkg::key_t            w_key,
  input  logic [6:0]               w_wild,
  input  logic [TIME_BITS-1:0]     w_expiry,
  input  logic [31:0]              w_idle,
  input  logic [31:0]              w_port,
  input  logic [31:0]              w_hits,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output fwt_pkg::key_t            r_key,
  output logic [6:0]               r_wild,
  output logic [TIME_BITS-1:0]     r_expiry,
  output logic [31:0]              r_idle,
  output logic [31:0]              r_port,
  output logic [31:0]              r_hits
);

  localparam int KW = $bits(fwt_pkg::key_t);
  localparam int EW = KW + 7 + TIME_BITS + 96;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rword;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {w_key, w_wild, w_expiry, w_idle, w_port, w_hits};
    end
    rword <= mem[raddr];
  end

  assign {r_key, r_wild, r_expiry, r_idle, r_port, r_hits} = rword;

endmodule

>>> rtl/fwt_match.sv
// Entry evaluation: expiry test, wildcard match and hit update.
module fwt_match #(
  parameter int TIME_BITS = 48
) (
  input  fwt_pkg::key_t        pkt,
  input  logic [TIME_BITS-1:0] now,
  input  logic [15:0]          syn_limit,
  input  fwt_pkg::key_t        e_key,
  input  logic [6:0]           e_wild,
  input  logic [TIME_BITS-1:0] e_expiry,
  input  logic [31:0]          e_idle,
  input  logic [31:0]          e_port,
  input  logic [31:0]          e_hits,
  output fwt_pkg::eval_t       res,
  output logic [TIME_BITS-1:0] expiry_new
);

  localparam int SUMW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [SUMW-1:0]      sum;
  logic [TIME_BITS-1:0] refreshed;
  logic                 kill;

  always_comb begin
    res.expired = (e_expiry < now);
    res.match = (e_wild[fwt_pkg::WB_IN_PORT]  || pkt.in_port  == e_key.in_port)
             && (e_wild[fwt_pkg::WB_ETH_TYPE] || pkt.eth_type == e_key.eth_type)
             && (e_wild[fwt_pkg::WB_ETH_SRC]  || pkt.eth_src  == e_key.eth_src)
             && (e_wild[fwt_pkg::WB_ETH_DST]  || pkt.eth_dst  == e_key.eth_dst)
             && (pkt.syn == e_key.syn)
             && (e_wild[fwt_pkg::WB_ACK]      || pkt.ack      == e_key.ack)
             && (e_wild[fwt_pkg::WB_IP_SRC]   || pkt.ip_src   == e_key.ip_src)
             && (e_wild[fwt_pkg::WB_IP_DST]   || pkt.ip_dst   == e_key.ip_dst);
    res.hits_new = (e_hits == fwt_pkg::HITS_MAX) ? e_hits : e_hits + 32'd1;

    // Saturate the idle refresh at the largest time.
    sum = SUMW'(now) + SUMW'(e_idle);
    if (e_idle == 32'd0) begin
      refreshed = e_expiry;
    end else if (sum > SUMW'(TMAX)) begin
      refreshed = TMAX;
    end else begin
      refreshed = sum[TIME_BITS-1:0];
    end

    // SYN-only flow toward a real port hit too often: expire it now.
    kill = (res.hits_new >= 32'(syn_limit)) && e_key.syn && !e_key.ack
        && (e_port != fwt_pkg::PORT_ANY);
    expiry_new = kill ? now : refreshed;
  end

endmodule

>>> rtl/wildcard_flow_table_lookup.sv
// Top level of the wildcard flow table: command sequencer, order and free lists, registers.
//
// Usage: present a command on the in_ ports with start high; it is taken at an edge where
// busy is low. One result follows, shown for a single cycle with out_valid high; the
// receiver cannot hold it off. A new command may be taken in the cycle the result shows.
// Add: the entry goes to the front of the priority list. A full table answers ST_FULL and
// stays unchanged. Otherwise a slot is allocated (a released slot from the stack, else a
// fresh one), the entry is written, each live entry is moved down the priority list in the
// order RAM by a read and a write, and the new entry is placed at the front.
// Lookup: the priority list is walked one position at a time, each entry up to the hit by
// order RAM read, entry RAM read and evaluate; after a hit, if entries were erased, the
// rest are moved up to close the holes; a finishing step gives the result.
// The order RAM, entry RAM and free-slot stack each have one registered read port.
// Reset: the table comes up empty, syn_hit_limit is 5 and the erased count is zero. No
// clearing pass is needed: never used slots are handed out by a fill counter, and
// released slots through a stack.
// Configuration: APB register syn_hit_limit at byte address 0, written while idle.
module wildcard_flow_table_lookup #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [47:0] in_time_value,
  input  logic [31:0] in_in_port,
  input  logic [15:0] in_eth_type,
  input  logic [47:0] in_eth_src,
  input  logic [47:0] in_eth_dst,
  input  logic [1:0]  in_tcp_flags,
  input  logic [31:0] in_ip_src,
  input  logic [31:0] in_ip_dst,
  input  logic [6:0]  in_wildcards,
  input  logic [31:0] in_idle_timeout,
  input  logic [31:0] in_out_port,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_action_port,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_erased_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam logic [LW-1:0] FULL = LW'(TABLE_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_ORD_RD = 10'b00_0000_0010,
    S_ENT_RD = 10'b00_0000_0100,
    S_EVAL   = 10'b00_0000_1000,
    S_FINISH = 10'b00_0001_0000,
    S_ALLOC  = 10'b00_0010_0000,
    S_ADD_WR = 10'b00_0100_0000,
    S_SH_RD  = 10'b00_1000_0000,
    S_SH_WR  = 10'b01_0000_0000,
    S_FRONT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Control registers.
  logic [LW-1:0] live_r, live_nxt;
  logic [LW-1:0] fcnt_r, fcnt_nxt;      // released slots on the free stack
  logic [LW-1:0] fresh_r, fresh_nxt;    // slots below this were handed out once
  logic [LW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] ecnt_r, ecnt_nxt;      // entries erased in this walk
  logic          hitf_r, hitf_nxt;
  logic [31:0]   erased_r, erased_nxt;
  logic [15:0]   limit_r, limit_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers.
  logic                 cmd_r;
  fwt_pkg::key_t        key_r;
  logic [TIME_BITS-1:0] t_r;
  logic [6:0]           wild_r;
  logic [31:0]          idle_r, port_r;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [31:0]          res_port_r, res_port_nxt;
  logic [31:0]          res_hits_r, res_hits_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [31:0]          out_port_r, out_port_nxt;
  logic [31:0]          out_hits_r, out_hits_nxt;

  logic accept;
  logic cfg_wr;
  logic [LW-1:0] pos_inc;

  // Order RAM (priority position -> slot) and free-slot stack.
  logic          ord_we, fre_we;
  logic [AW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic [AW-1:0] fre_waddr, fre_raddr, fre_rdata;

  // Entry RAM.
  logic                 ent_we;
  logic [AW-1:0]        ent_raddr;
  fwt_pkg::key_t        ent_wkey, e_key;
  logic [6:0]           ent_wwild, e_wild;
  logic [TIME_BITS-1:0] ent_wexp, e_expiry;
  logic [31:0]          ent_widle, ent_wport, ent_whits, e_idle, e_port, e_hits;

  fwt_pkg::eval_t       ev;
  logic [TIME_BITS-1:0] exp_new;

  function automatic logic [LW-1:0] slot_idx_dec(input logic [LW-1:0] v);
    slot_idx_dec = v - LW'(1);
  endfunction

  fwt_idx_ram #(.DEPTH(TABLE_DEPTH), .W(AW)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  fwt_idx_ram #(.DEPTH(TABLE_DEPTH), .W(AW)) u_free (
    .clk(clk), .we(fre_we), .waddr(fre_waddr), .wdata(slot_r),
    .raddr(fre_raddr), .rdata(fre_rdata)
  );

  fwt_entry_mem #(.DEPTH(TABLE_DEPTH), .TIME_BITS(TIME_BITS)) u_entries (
    .clk(clk), .we(ent_we), .waddr(slot_r),
    .w_key(ent_wkey), .w_wild(ent_wwild), .w_expiry(ent_wexp),
    .w_idle(ent_widle), .w_port(ent_wport), .w_hits(ent_whits),
    .raddr(ent_raddr),
    .r_key(e_key), .r_wild(e_wild), .r_expiry(e_expiry),
    .r_idle(e_idle), .r_port(e_port), .r_hits(e_hits)
  );

  fwt_match #(.TIME_BITS(TIME_BITS)) u_match (
    .pkt(key_r), .now(t_r), .syn_limit(limit_r),
    .e_key(e_key), .e_wild(e_wild), .e_expiry(e_expiry),
    .e_idle(e_idle), .e_port(e_port), .e_hits(e_hits),
    .res(ev), .expiry_new(exp_new)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == fwt_pkg::REG_SYN_LIMIT) ? {16'd0, limit_r} : 32'd0;
  assign pos_inc   = pos_r + LW'(1);

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_action_port  = out_port_r;
  assign out_hit_count    = out_hits_r;
  assign out_erased_total = erased_r;

  // Address and data selection for the memories.
  always_comb begin
    ord_raddr = pos_r[AW-1:0];
    if (state_r == S_SH_RD) begin
      ord_raddr = AW'(slot_idx_dec(pos_r));
    end
    fre_raddr = AW'(fcnt_r - LW'(1));
    fre_waddr = fcnt_r[AW-1:0];
    ent_raddr = ord_rdata;

    ent_wkey  = e_key;
    ent_wwild = e_wild;
    ent_wexp  = exp_new;
    ent_widle = e_idle;
    ent_wport = e_port;
    ent_whits = ev.hits_new;
    if (state_r == S_ADD_WR) begin
      ent_wkey  = key_r;
      ent_wwild = wild_r;
      ent_wexp  = t_r;
      ent_widle = idle_r;
      ent_wport = port_r;
      ent_whits = 32'd1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    live_nxt       = live_r;
    fcnt_nxt       = fcnt_r;
    fresh_nxt      = fresh_r;
    pos_nxt        = pos_r;
    ecnt_nxt       = ecnt_r;
    hitf_nxt       = hitf_r;
    erased_nxt     = erased_r;
    limit_nxt      = limit_r;
    out_valid_nxt  = 1'b0;
    slot_nxt       = slot_r;
    res_port_nxt   = res_port_r;
    res_hits_nxt   = res_hits_r;
    out_status_nxt = out_status_r;
    out_port_nxt   = out_port_r;
    out_hits_nxt   = out_hits_r;
    ord_we         = 1'b0;
    ord_waddr      = AW'(pos_r - ecnt_r);
    ord_wdata      = ord_rdata;
    fre_we         = 1'b0;
    ent_we         = 1'b0;

    if (cfg_wr && paddr[2] == fwt_pkg::REG_SYN_LIMIT) begin
      limit_nxt = pwdata[15:0];
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt  = '0;
          ecnt_nxt = '0;
          hitf_nxt = 1'b0;
          if (in_cmd == fwt_pkg::CMD_LOOKUP) begin
            state_nxt = (live_r == '0) ? S_FINISH : S_ORD_RD;
          end else if (live_r == FULL) begin
            // Full table: answer at once, nothing changes.
            out_valid_nxt  = 1'b1;
            out_status_nxt = fwt_pkg::ST_FULL;
            out_port_nxt   = '0;
            out_hits_nxt   = '0;
          end else if (fcnt_r != '0) begin
            state_nxt = S_ALLOC;
          end else begin
            slot_nxt  = fresh_r[AW-1:0];
            fresh_nxt = fresh_r + LW'(1);
            state_nxt = S_ADD_WR;
          end
        end
      end
      S_ORD_RD: begin
        state_nxt = S_ENT_RD;
      end
      S_ENT_RD: begin
        slot_nxt = ord_rdata;
        if (hitf_r) begin
          // Past the hit: close the holes left by erased entries.
          ord_we    = 1'b1;
          pos_nxt   = pos_inc;
          state_nxt = (pos_inc == live_r) ? S_FINISH : S_ORD_RD;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ord_wdata = slot_r;
        pos_nxt   = pos_inc;
        state_nxt = (pos_inc == live_r) ? S_FINISH : S_ORD_RD;
        if (ev.expired) begin
          // Drop the entry and release its slot.
          fre_we   = 1'b1;
          fcnt_nxt = fcnt_r + LW'(1);
          ecnt_nxt = ecnt_r + LW'(1);
          if (erased_r != fwt_pkg::ERASED_MAX) begin
            erased_nxt = erased_r + 32'd1;
          end
        end else begin
          ord_we = (ecnt_r != '0);
          if (ev.match) begin
            ent_we       = 1'b1;
            hitf_nxt     = 1'b1;
            res_port_nxt = e_port;
            res_hits_nxt = ev.hits_new;
            if (ecnt_r == '0) begin
              state_nxt = S_FINISH;
            end
          end
        end
      end
      S_FINISH: begin
        live_nxt       = live_r - ecnt_r;
        out_valid_nxt  = 1'b1;
        out_status_nxt = hitf_r ? fwt_pkg::ST_HIT : fwt_pkg::ST_MISS;
        out_port_nxt   = hitf_r ? res_port_r : 32'd0;
        out_hits_nxt   = hitf_r ? res_hits_r : 32'd0;
        state_nxt      = S_IDLE;
      end
      S_ALLOC: begin
        slot_nxt  = fre_rdata;
        fcnt_nxt  = fcnt_r - LW'(1);
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        ent_we    = 1'b1;
        pos_nxt   = live_r;
        state_nxt = (live_r == '0) ? S_FRONT : S_SH_RD;
      end
      S_SH_RD: begin
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        // Move one position down the priority list.
        ord_we    = 1'b1;
        ord_waddr = pos_r[AW-1:0];
        pos_nxt   = slot_idx_dec(pos_r);
        state_nxt = (pos_r == LW'(1)) ? S_FRONT : S_SH_RD;
      end
      S_FRONT: begin
        ord_we         = 1'b1;
        ord_waddr      = '0;
        ord_wdata      = slot_r;
        live_nxt       = live_r + LW'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = fwt_pkg::ST_ADDED;
        out_port_nxt   = '0;
        out_hits_nxt   = '0;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      fcnt_r      <= '0;
      fresh_r     <= '0;
      pos_r       <= '0;
      ecnt_r      <= '0;
      hitf_r      <= 1'b0;
      erased_r    <= '0;
      limit_r     <= fwt_pkg::SYN_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      fcnt_r      <= fcnt_nxt;
      fresh_r     <= fresh_nxt;
      pos_r       <= pos_nxt;
      ecnt_r      <= ecnt_nxt;
      hitf_r      <= hitf_nxt;
      erased_r    <= erased_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the command payload; hold it for the whole walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= in_cmd;
      t_r          <= TIME_BITS'(in_time_value);
      key_r.in_port  <= in_in_port;
      key_r.eth_type <= in_eth_type;
      key_r.eth_src  <= in_eth_src;
      key_r.eth_dst  <= in_eth_dst;
      key_r.syn      <= in_tcp_flags[0];
      key_r.ack      <= in_tcp_flags[1];
      key_r.ip_src   <= in_ip_src;
      key_r.ip_dst   <= in_ip_dst;
      wild_r       <= in_wildcards;
      idle_r       <= in_idle_timeout;
      port_r       <= in_out_port;
    end
    slot_r       <= slot_nxt;
    res_port_r   <= res_port_nxt;
    res_hits_r   <= res_hits_nxt;
    out_status_r <= out_status_nxt;
    out_port_r   <= out_port_nxt;
    out_hits_r   <= out_hits_nxt;
  end

`ifndef SYNTHESIS
  // Every slot is live, on the free stack or not yet handed out.
  a_slot_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (live_r + fcnt_r + (FULL - fresh_r) == FULL))
    else $error("slot accounting broken");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= FULL)
    else $error("live count above table depth");

  a_erase_behind_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (ecnt_r <= pos_r && pos_r < live_r))
    else $error("walk position out of range");

  a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH || state_r == S_FRONT) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result transfer missing after command");

  a_lookup_only_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (cmd_r == fwt_pkg::CMD_LOOKUP))
    else $error("entry evaluation outside a lookup");
`endif

endmodule
